FILE: hw/rtl/core_local_interruptor_macros.svh
// assertion macros for the core local interruptor
// used by the files that assert, no other dependencies
`ifndef CORE_LOCAL_INTERRUPTOR_MACROS_SVH
`define CORE_LOCAL_INTERRUPTOR_MACROS_SVH
`ifndef SYNTHESIS
`define CLI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CLI_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLI_ASSERT(label, clk, rst_n, prop, msg)
`define CLI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/cli_pkg.sv
// types and constants shared by the core local interruptor modules
// no dependencies
package cli_pkg;

    localparam int OFFSET_W = 16;
    localparam int SIZE_W   = 4;
    localparam int DATA_W   = 64;
    localparam int HALF_W   = 32;
    localparam int IDX_W    = 12;
    localparam int LINES_W  = 4;

    localparam logic [OFFSET_W-1:0] WIN_COMPARE = 16'h4000;
    localparam logic [OFFSET_W-1:0] WIN_TIME    = 16'hBFF8;
    localparam logic [OFFSET_W-1:0] WIN_END     = 16'hC000;

    localparam logic [SIZE_W-1:0] SIZE_WORD  = 4'd4;
    localparam logic [SIZE_W-1:0] SIZE_DWORD = 4'd8;

    localparam logic [DATA_W-1:0] CMP_RESET = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_RSVD  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ADDR_ERR = 2'd1,
        ST_GEN_ERR  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_TICK = 3'd1,
        TGT_SOFT = 3'd2,
        TGT_CMP  = 3'd3,
        TGT_TIME = 3'd4
    } t_target;

    typedef struct packed {
        t_target          target;
        t_status          status;
        logic             is_write;
        logic             dword;
        logic             high_half;
        logic [IDX_W-1:0] idx;
    } t_dec;

endpackage

FILE: hw/rtl/cli_decode.sv
// address and length decode of one request into target, core index and status
// depends on cli_pkg
module cli_decode (
    input  cli_pkg::t_action                 i_action,
    input  logic [cli_pkg::OFFSET_W-1:0]     i_offset,
    input  logic [cli_pkg::SIZE_W-1:0]       i_size,
    output cli_pkg::t_dec                    o_dec
);

    logic                          w_misalign;
    logic                          w_size_ok;
    logic [cli_pkg::OFFSET_W-1:0]  w_rel;

    assign w_misalign = (i_offset[1:0] != 2'b00);
    assign w_size_ok  = (i_size == cli_pkg::SIZE_WORD) || (i_size == cli_pkg::SIZE_DWORD);
    assign w_rel      = i_offset - cli_pkg::WIN_COMPARE;

    always_comb begin
        o_dec.target    = cli_pkg::TGT_NONE;
        o_dec.status    = cli_pkg::ST_OK;
        o_dec.is_write  = (i_action == cli_pkg::ACT_WRITE);
        o_dec.dword     = (i_size == cli_pkg::SIZE_DWORD);
        o_dec.high_half = i_offset[2];
        o_dec.idx       = '0;
        case (i_action)
            cli_pkg::ACT_TICK: begin
                o_dec.target = cli_pkg::TGT_TICK;
            end
            cli_pkg::ACT_READ, cli_pkg::ACT_WRITE: begin
                if (i_offset < cli_pkg::WIN_COMPARE) begin
                    if (w_misalign) begin
                        o_dec.status = cli_pkg::ST_ADDR_ERR;
                    end else if (i_size != cli_pkg::SIZE_WORD) begin
                        o_dec.status = cli_pkg::ST_GEN_ERR;
                    end else begin
                        o_dec.target = cli_pkg::TGT_SOFT;
                        o_dec.idx    = i_offset[13:2];
                    end
                end else if (i_offset < cli_pkg::WIN_END) begin
                    if (w_misalign) begin
                        o_dec.status = cli_pkg::ST_ADDR_ERR;
                    end else if (!w_size_ok) begin
                        o_dec.status = cli_pkg::ST_GEN_ERR;
                    end else if (o_dec.dword && i_offset[2]) begin
                        o_dec.status = cli_pkg::ST_ADDR_ERR;
                    end else if (i_offset >= cli_pkg::WIN_TIME) begin
                        o_dec.target = cli_pkg::TGT_TIME;
                    end else begin
                        o_dec.target = cli_pkg::TGT_CMP;
                        o_dec.idx    = w_rel[14:3];
                    end
                end else begin
                    o_dec.status = cli_pkg::ST_ADDR_ERR;
                end
            end
            default: begin
                o_dec.status = cli_pkg::ST_GEN_ERR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cli_regfile.sv
// soft bits, timer compares, time counter and timer lines with read and write paths
// depends on cli_pkg and core_local_interruptor_macros.svh
`include "core_local_interruptor_macros.svh"

module cli_regfile #(
    parameter int CORE_COUNT = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  cli_pkg::t_dec                  i_dec,
    input  logic [cli_pkg::DATA_W-1:0]     i_wdata,
    output logic [cli_pkg::DATA_W-1:0]     o_rdata,
    output cli_pkg::t_status               o_status,
    output logic [cli_pkg::LINES_W-1:0]    o_timer_lines,
    output logic [cli_pkg::LINES_W-1:0]    o_soft_lines
);

    localparam int CORE_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

    logic [CORE_COUNT-1:0]         r_soft;
    logic [CORE_COUNT-1:0]         r_timer;
    logic [cli_pkg::DATA_W-1:0]    r_cmp [CORE_COUNT];
    logic [cli_pkg::DATA_W-1:0]    r_time;

    logic [CORE_COUNT-1:0]         n_soft;
    logic [CORE_COUNT-1:0]         n_timer;
    logic [cli_pkg::DATA_W-1:0]    n_time;
    logic                          n_cmp_we;

    logic [CORE_COUNT-1:0]         w_hit;
    logic                          w_core_ok;
    logic [CORE_W-1:0]             w_core;
    logic [cli_pkg::DATA_W-1:0]    w_reg64;
    logic [cli_pkg::DATA_W-1:0]    w_rd64;
    logic [cli_pkg::DATA_W-1:0]    w_wr64;

    assign w_core_ok = (i_dec.idx < cli_pkg::IDX_W'(CORE_COUNT));
    assign w_core    = i_dec.idx[CORE_W-1:0];
    assign w_reg64   = (i_dec.target == cli_pkg::TGT_TIME) ? r_time : r_cmp[w_core];

    always_comb begin
        for (int c = 0; c < CORE_COUNT; c++) begin
            w_hit[c] = (r_time >= r_cmp[c]);
        end
    end

    always_comb begin
        if (i_dec.dword) begin
            w_rd64 = w_reg64;
            w_wr64 = i_wdata;
        end else if (i_dec.high_half) begin
            w_rd64 = {{cli_pkg::HALF_W{1'b0}}, w_reg64[cli_pkg::DATA_W-1:cli_pkg::HALF_W]};
            w_wr64 = {i_wdata[cli_pkg::HALF_W-1:0], w_reg64[cli_pkg::HALF_W-1:0]};
        end else begin
            w_rd64 = {{cli_pkg::HALF_W{1'b0}}, w_reg64[cli_pkg::HALF_W-1:0]};
            w_wr64 = {w_reg64[cli_pkg::DATA_W-1:cli_pkg::HALF_W], i_wdata[cli_pkg::HALF_W-1:0]};
        end
    end

    always_comb begin
        o_status = i_dec.status;
        o_rdata  = '0;
        n_soft   = r_soft;
        n_timer  = r_timer;
        n_time   = r_time;
        n_cmp_we = 1'b0;
        case (i_dec.target)
            cli_pkg::TGT_TICK: begin
                n_timer = w_hit;
                n_time  = r_time + cli_pkg::DATA_W'(1);
            end
            cli_pkg::TGT_SOFT: begin
                if (!w_core_ok) begin
                    o_status = cli_pkg::ST_ADDR_ERR;
                end else if (i_dec.is_write) begin
                    n_soft[w_core] = i_wdata[0];
                end else begin
                    o_rdata = {{(cli_pkg::DATA_W-1){1'b0}}, r_soft[w_core]};
                end
            end
            cli_pkg::TGT_CMP: begin
                if (!w_core_ok) begin
                    o_status = cli_pkg::ST_ADDR_ERR;
                end else if (i_dec.is_write) begin
                    n_cmp_we = 1'b1;
                end else begin
                    o_rdata = w_rd64;
                end
            end
            cli_pkg::TGT_TIME: begin
                if (i_dec.is_write) begin
                    n_time = w_wr64;
                end else begin
                    o_rdata = w_rd64;
                end
            end
            default: begin
            end
        endcase
    end

    // lines after this beat has taken effect, cores beyond the first four not shown
    genvar g;
    generate
        for (g = 0; g < cli_pkg::LINES_W; g++) begin : g_lines
            if (g < CORE_COUNT) begin : g_on
                assign o_soft_lines[g]  = n_soft[g];
                assign o_timer_lines[g] = n_timer[g];
            end else begin : g_off
                assign o_soft_lines[g]  = 1'b0;
                assign o_timer_lines[g] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft  <= '0;
            r_timer <= '0;
            r_time  <= '0;
            for (int c = 0; c < CORE_COUNT; c++) begin
                r_cmp[c] <= cli_pkg::CMP_RESET;
            end
        end else if (i_en) begin
            r_soft  <= n_soft;
            r_timer <= n_timer;
            r_time  <= n_time;
            if (n_cmp_we) begin
                r_cmp[w_core] <= w_wr64;
            end
        end
    end

    `CLI_ASSERT(a_tick_counts, i_clk, i_rst_n, i_en && (i_dec.target == cli_pkg::TGT_TICK) |=> r_time == $past(r_time) + 64'd1, "time did not advance on tick")
    `CLI_ASSERT(a_idle_holds, i_clk, i_rst_n, !i_en |=> $stable(r_time) && $stable(r_soft) && $stable(r_timer), "state changed without a beat")
    `CLI_ASSERT(a_err_no_read, i_clk, i_rst_n, o_status != cli_pkg::ST_OK |-> o_rdata == 64'd0, "read data on error")

endmodule

FILE: hw/rtl/core_local_interruptor.sv
// top level of the core local interruptor: input register, decode, register file, result register
// depends on cli_pkg, cli_decode, cli_regfile and core_local_interruptor_macros.svh
//
//  channel   dir  tdata                                             tuser
//  s_axis    in   offset[15:0] size_bytes[19:16] write_value[83:20]  action[1:0]
//  m_axis    out  read_value[63:0] timer_lines[67:64] soft_lines[71:68]  status[1:0]
//
// one beat per cycle sustained while m_axis_tready stays high; a taken beat is held in the
// input register, then goes through the single decode/update pass into the result register
// every input beat gives exactly one output beat, in order
// m_axis_tready low holds the result and then the input register; s_axis_tready drops once both hold
// reset is synchronous and clears valid flags and register file state at once, no clearing pass
`include "core_local_interruptor_macros.svh"

module core_local_interruptor #(
    parameter int CORE_COUNT = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // offset, size_bytes, write_value, top bits ignored
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // read_value, timer_lines, soft_lines
    output logic [1:0]  m_axis_tuser    // status
);

    logic                              r_in_valid;
    cli_pkg::t_action                  r_in_action;
    logic [cli_pkg::OFFSET_W-1:0]      r_in_offset;
    logic [cli_pkg::SIZE_W-1:0]        r_in_size;
    logic [cli_pkg::DATA_W-1:0]        r_in_wdata;

    logic                              r_out_valid;
    logic [cli_pkg::DATA_W-1:0]        r_out_rdata;
    cli_pkg::t_status                  r_out_status;
    logic [cli_pkg::LINES_W-1:0]       r_out_timer;
    logic [cli_pkg::LINES_W-1:0]       r_out_soft;

    logic                              w_adv;
    cli_pkg::t_dec                     w_dec;
    logic [cli_pkg::DATA_W-1:0]        w_rdata;
    cli_pkg::t_status                  w_status;
    logic [cli_pkg::LINES_W-1:0]       w_timer;
    logic [cli_pkg::LINES_W-1:0]       w_soft;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= cli_pkg::t_action'(s_axis_tuser);
            r_in_offset <= s_axis_tdata[15:0];
            r_in_size   <= s_axis_tdata[19:16];
            r_in_wdata  <= s_axis_tdata[83:20];
        end
    end

    cli_decode u_decode (
        .i_action (r_in_action),
        .i_offset (r_in_offset),
        .i_size   (r_in_size),
        .o_dec    (w_dec)
    );

    cli_regfile #(
        .CORE_COUNT (CORE_COUNT)
    ) u_regfile (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_dec         (w_dec),
        .i_wdata       (r_in_wdata),
        .o_rdata       (w_rdata),
        .o_status      (w_status),
        .o_timer_lines (w_timer),
        .o_soft_lines  (w_soft)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_rdata  <= w_rdata;
            r_out_status <= w_status;
            r_out_timer  <= w_timer;
            r_out_soft   <= w_soft;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_soft, r_out_timer, r_out_rdata};
    assign m_axis_tuser  = r_out_status;

    `CLI_ASSERT(a_beat_reaches_out, i_clk, i_rst_n, w_adv |=> r_out_valid, "taken beat lost before output")
    `CLI_ASSERT(a_in_held, i_clk, i_rst_n, r_in_valid && !w_adv |=> r_in_valid, "blocked beat dropped")
    `CLI_ASSERT(a_err_zero_data, i_clk, i_rst_n, r_out_valid && (r_out_status != cli_pkg::ST_OK) |-> r_out_rdata == 64'd0, "error beat with read data")

endmodule
